### sv/imucf_pkg.sv
// Shared types, command codes and constant tables of the IMU attitude filter.
package imucf_pkg;

    typedef struct packed {
        logic signed [15:0] accel_raw_x;
        logic signed [15:0] accel_raw_y;
        logic signed [15:0] accel_raw_z;
        logic signed [15:0] gyro_raw_x;
        logic signed [15:0] gyro_raw_y;
        logic signed [15:0] gyro_raw_z;
        logic        [31:0] time_ms;
    } imucf_in_t;

    typedef struct packed {
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
    } imucf_out_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFF_Z  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFF_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFF_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFF_Z = 3'd7;

    localparam int DIV_W      = 66;  // dividend / quotient width of the serial divider
    localparam int SQRT_STEPS = 31;  // root bits of the 62-bit radicand
    localparam int STEP_W     = 7;

    localparam logic [STEP_W-1:0] DIV_LAST  = 7'(DIV_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = 7'(SQRT_STEPS - 1);

    // ceil(2^28 / 25): exact floor division by 25 for operands below 2^23
    localparam logic [23:0] RECIP_25   = 24'd10737419;
    localparam logic [37:0] BLEND_HALF = 38'd12;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_G_STORE,
        OP_SQUARE,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_C_INIT,
        OP_C_STEP,
        OP_B_INIT,
        OP_B_DIV,
        OP_B_STORE,
        OP_OUT
    } imucf_op_t;

    typedef struct packed {
        imucf_op_t          op;
        logic [1:0]         axis;
        logic [STEP_W-1:0]  step;
    } imucf_cmd_t;

    // ten times the sensitivity, times 100: 131.0, 65.5, 32.8, 16.4 LSB per deg/s
    function automatic logic [16:0] gyro_div(input logic [1:0] sel);
        logic [16:0] d;
        unique case (sel)
            2'd0: d = 17'd131000;
            2'd1: d = 17'd65500;
            2'd2: d = 17'd32800;
            2'd3: d = 17'd16400;
        endcase
        return d;
    endfunction

    // atan(2^-i) in Q16.16 degrees
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] a;
        unique case (i)
            5'd0:  a = 22'd2949120;
            5'd1:  a = 22'd1740967;
            5'd2:  a = 22'd919879;
            5'd3:  a = 22'd466945;
            5'd4:  a = 22'd234379;
            5'd5:  a = 22'd117304;
            5'd6:  a = 22'd58666;
            5'd7:  a = 22'd29335;
            5'd8:  a = 22'd14668;
            5'd9:  a = 22'd7334;
            5'd10: a = 22'd3667;
            5'd11: a = 22'd1833;
            5'd12: a = 22'd917;
            5'd13: a = 22'd458;
            5'd14: a = 22'd229;
            5'd15: a = 22'd115;
            5'd16: a = 22'd57;
            5'd17: a = 22'd29;
            5'd18: a = 22'd14;
            5'd19: a = 22'd7;
            5'd20: a = 22'd4;
            5'd21: a = 22'd2;
            5'd22: a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/imucf_ctrl.sv
// Sequencer of the IMU attitude filter: steps the datapath through each request.
module imucf_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output imucf_pkg::imucf_cmd_t  cmd
);
    import imucf_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_MUL     = 14'b00000000000010,
        ST_DIVINIT = 14'b00000000000100,
        ST_DIV     = 14'b00000000001000,
        ST_GSTORE  = 14'b00000000010000,
        ST_SQUARE  = 14'b00000000100000,
        ST_SQINIT  = 14'b00000001000000,
        ST_SQRT    = 14'b00000010000000,
        ST_CINIT   = 14'b00000100000000,
        ST_CORDIC  = 14'b00001000000000,
        ST_BINIT   = 14'b00010000000000,
        ST_BDIV    = 14'b00100000000000,
        ST_BSTORE  = 14'b01000000000000,
        ST_FINISH  = 14'b10000000000000
    } state_t;

    localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(CORDIC_STEPS - 1);

    state_t            state_reg, state_next;
    logic [1:0]        axis_reg, axis_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd.op       = OP_NONE;
        cmd.axis     = axis_reg;
        cmd.step     = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    axis_next  = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.op     = OP_MUL;
                state_next = ST_DIVINIT;
            end
            ST_DIVINIT: begin
                cmd.op     = OP_DIV_INIT;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op    = OP_DIV_STEP;
                step_next = step_reg + 7'd1;
                if (step_reg == DIV_LAST) begin
                    state_next = ST_GSTORE;
                end
            end
            ST_GSTORE: begin
                cmd.op = OP_G_STORE;
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    state_next = ST_SQUARE;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_SQUARE: begin
                cmd.op     = OP_SQUARE;
                state_next = ST_SQINIT;
            end
            ST_SQINIT: begin
                cmd.op     = OP_SQ_INIT;
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op    = OP_SQ_STEP;
                step_next = step_reg + 7'd1;
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT: begin
                cmd.op     = OP_C_INIT;
                step_next  = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.op    = OP_C_STEP;
                step_next = step_reg + 7'd1;
                if (step_reg == CORDIC_LAST) begin
                    state_next = ST_BINIT;
                end
            end
            ST_BINIT: begin
                cmd.op     = OP_B_INIT;
                state_next = ST_BDIV;
            end
            ST_BDIV: begin
                cmd.op     = OP_B_DIV;
                state_next = ST_BSTORE;
            end
            ST_BSTORE: begin
                cmd.op = OP_B_STORE;
                if (axis_reg == 2'd1) begin
                    state_next = ST_FINISH;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SQUARE;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### sv/imucf_datapath.sv
// Datapath of the IMU attitude filter: config, state, multiplier, divider, root, CORDIC.
module imucf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  imucf_pkg::imucf_cmd_t               cmd,
    input  imucf_pkg::imucf_in_t                s_data,
    output imucf_pkg::imucf_out_t               m_data,
    input  logic                                cfg_we,
    input  logic [imucf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imucf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import imucf_pkg::*;

    logic [1:0]         gyro_range_reg;
    logic [1:0]         accel_range_reg;
    logic signed [15:0] gyro_off_reg [3];
    logic [14:0]        accel_off_reg [3];

    imucf_in_t          in_reg;
    logic [31:0]        dt_reg;
    logic [31:0]        prev_time_reg;
    logic               have_time_reg;
    logic signed [31:0] angle_reg [3];
    logic signed [31:0] g_reg [3];
    logic [48:0]        p_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [16:0]        rem_reg;
    logic [16:0]        den_reg;
    logic [31:0]        bb_reg;
    logic [31:0]        cc_reg;
    logic [61:0]        sq_n_reg;
    logic [31:0]        sq_rem_reg;
    logic [30:0]        root_reg;
    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic               tz_reg;
    logic               neg_reg;
    logic [35:0]        bm_reg;
    logic [13:0]        bq_reg;
    logic [22:0]        bx_reg;
    imucf_out_t         out_reg;

    logic signed [16:0] acc [3];
    logic signed [16:0] gd [3];
    logic signed [16:0] gsel, ta, tb, tc;
    logic [16:0]        gmag;
    logic [16:0]        gdiv;
    logic [17:0]        rem2;
    logic               qbit;
    logic [17:0]        rem_diff;
    logic [33:0]        r2, rt;
    logic signed [35:0] xs, ys;
    logic signed [31:0] gb, prev_sel, tilt;
    logic signed [37:0] bn;
    logic [37:0]        bmag;
    logic [46:0]        qa_prod, qx_prod;
    logic [13:0]        qa;
    logic [17:0]        qa25, ra_full;
    logic [32:0]        bq;
    logic signed [67:0] gsum, bres;

    always_comb begin
        acc[0] = 17'(in_reg.accel_raw_x) - ((accel_range_reg != 2'd0) ?
                 $signed({2'b00, accel_off_reg[0]}) : 17'sd0);
        acc[1] = 17'(in_reg.accel_raw_y) - ((accel_range_reg != 2'd0) ?
                 $signed({2'b00, accel_off_reg[1]}) : 17'sd0);
        acc[2] = 17'(in_reg.accel_raw_z) - ((accel_range_reg != 2'd0) ?
                 $signed({2'b00, accel_off_reg[2]}) : 17'sd0);
        gd[0]  = 17'(in_reg.gyro_raw_x) - 17'(gyro_off_reg[0]);
        gd[1]  = 17'(in_reg.gyro_raw_y) - 17'(gyro_off_reg[1]);
        gd[2]  = 17'(in_reg.gyro_raw_z) - 17'(gyro_off_reg[2]);

        unique case (cmd.axis)
            2'd0: begin
                gsel = gd[0]; gb = g_reg[0]; prev_sel = angle_reg[0];
                ta = acc[0]; tb = acc[1];
            end
            2'd1: begin
                gsel = gd[1]; gb = g_reg[1]; prev_sel = angle_reg[1];
                ta = acc[1]; tb = acc[0];
            end
            default: begin
                gsel = gd[2]; gb = g_reg[2]; prev_sel = angle_reg[2];
                ta = acc[1]; tb = acc[0];
            end
        endcase
        tc   = acc[2];
        gmag = gsel[16] ? 17'(-gsel) : 17'(gsel);
        gdiv = gyro_div(gyro_range_reg);

        rem2     = {rem_reg, num_reg[DIV_W-1]};
        qbit     = (rem2 >= {1'b0, den_reg});
        rem_diff = rem2 - {1'b0, den_reg};

        r2 = {sq_rem_reg, sq_n_reg[61:60]};
        rt = {1'b0, root_reg, 2'b01};

        xs = cx_reg >>> cmd.step[4:0];
        ys = cy_reg >>> cmd.step[4:0];

        gsum = gsel[16] ? (68'(prev_sel) - $signed({2'b00, num_reg}))
                        : (68'(prev_sel) + $signed({2'b00, num_reg}));

        tilt = tz_reg ? 32'sd0 : cz_reg;
        bn   = (38'(gb) <<< 4) + (38'(gb) <<< 3) + 38'(tilt);
        bmag = (bn[37] ? 38'(-bn) : 38'(bn)) + BLEND_HALF;

        // divide by 25 in two 18-bit halves by reciprocal multiplication
        qa_prod = 47'(bm_reg[35:18]) * 47'(RECIP_25);
        qa      = qa_prod[41:28];
        qa25    = 18'(qa) * 18'd25;
        ra_full = bm_reg[35:18] - qa25;
        qx_prod = 47'(bx_reg) * 47'(RECIP_25);
        bq      = {1'b0, bq_reg, 18'd0} + 33'(qx_prod[46:28]);
        bres    = neg_reg ? -$signed({35'd0, bq}) : $signed({35'd0, bq});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_range_reg  <= '0;
            accel_range_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                gyro_off_reg[i]  <= '0;
                accel_off_reg[i] <= '0;
                angle_reg[i]     <= '0;
            end
            prev_time_reg <= '0;
            have_time_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_GYRO_RANGE:  gyro_range_reg   <= cfg_wdata[1:0];
                    REG_ACCEL_RANGE: accel_range_reg  <= cfg_wdata[1:0];
                    REG_GYRO_OFF_X:  gyro_off_reg[0]  <= cfg_wdata;
                    REG_GYRO_OFF_Y:  gyro_off_reg[1]  <= cfg_wdata;
                    REG_GYRO_OFF_Z:  gyro_off_reg[2]  <= cfg_wdata;
                    REG_ACCEL_OFF_X: accel_off_reg[0] <= cfg_wdata[14:0];
                    REG_ACCEL_OFF_Y: accel_off_reg[1] <= cfg_wdata[14:0];
                    REG_ACCEL_OFF_Z: accel_off_reg[2] <= cfg_wdata[14:0];
                endcase
            end
            if (cmd.op == OP_B_STORE) begin
                angle_reg[cmd.axis[0]] <= sat32(bres);
            end
            if (cmd.op == OP_OUT) begin
                angle_reg[2]  <= g_reg[2];
                prev_time_reg <= in_reg.time_ms;
                have_time_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                in_reg <= s_data;
                dt_reg <= have_time_reg ? (s_data.time_ms - prev_time_reg) : 32'd0;
            end
            OP_MUL: begin
                p_reg <= 49'(gmag) * 49'(dt_reg);
            end
            OP_DIV_INIT: begin
                num_reg <= {1'b0, p_reg, 16'd0} + DIV_W'(gdiv[16:1]);
                den_reg <= gdiv;
                rem_reg <= '0;
            end
            OP_DIV_STEP: begin
                num_reg <= {num_reg[DIV_W-2:0], qbit};
                rem_reg <= qbit ? rem_diff[16:0] : rem2[16:0];
            end
            OP_G_STORE: begin
                g_reg[cmd.axis] <= sat32(gsum);
            end
            OP_SQUARE: begin
                bb_reg <= 32'(tb * tb);
                cc_reg <= 32'(tc * tc);
            end
            OP_SQ_INIT: begin
                sq_n_reg   <= {(33'(bb_reg) + 33'(cc_reg)), 29'd0} >> 1;
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            OP_SQ_STEP: begin
                sq_n_reg <= {sq_n_reg[59:0], 2'b00};
                if (r2 >= rt) begin
                    sq_rem_reg <= 32'(r2 - rt);
                    root_reg   <= {root_reg[29:0], 1'b1};
                end else begin
                    sq_rem_reg <= r2[31:0];
                    root_reg   <= {root_reg[29:0], 1'b0};
                end
            end
            OP_C_INIT: begin
                cx_reg <= $signed({5'd0, root_reg});
                cy_reg <= 36'(ta) <<< 14;
                cz_reg <= '0;
                tz_reg <= (root_reg == '0) && (ta == 17'sd0);
            end
            OP_C_STEP: begin
                if (!cy_reg[35]) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + $signed({10'd0, atan_deg(cmd.step[4:0])});
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - $signed({10'd0, atan_deg(cmd.step[4:0])});
                end
            end
            OP_B_INIT: begin
                bm_reg  <= bmag[35:0];
                neg_reg <= bn[37];
            end
            OP_B_DIV: begin
                bq_reg <= qa;
                bx_reg <= {ra_full[4:0], bm_reg[17:0]};
            end
            OP_OUT: begin
                out_reg.angle_x <= angle_reg[0];
                out_reg.angle_y <= angle_reg[1];
                out_reg.angle_z <= g_reg[2];
            end
            OP_NONE, OP_B_STORE: begin
            end
            default: begin
            end
        endcase
    end

    assign m_data = out_reg;

endmodule

### sv/imu_complementary_attitude_filter.sv
// Top level of the IMU complementary attitude filter.
// One request (accel and gyro triple plus a millisecond timestamp) yields one result of three
// Q16.16 degree angles. Most of the work per request is the shared one-bit-per-cycle 66-bit
// divider, run once per gyro axis, plus a 31-step square root and the CORDIC for each of x and
// y; the blend divide by 25 of each of those axes works on the upper and then the lower half of
// its operand. Requests are worked one at a time and the next one can be accepted in the same
// cycle that the result appears at the earliest; a finished result waits in the output register
// while the next request is taken. The user must write configuration only while idle; the
// block itself does not enforce it.
module imu_complementary_attitude_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  imucf_pkg::imucf_in_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output imucf_pkg::imucf_out_t               m_data,
    input  logic                                cfg_we,
    input  logic [imucf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imucf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import imucf_pkg::*;

    imucf_cmd_t cmd;

    imucf_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    imucf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

### test/imu_complementary_attitude_filter_test.sv
// Self-checking testbench of the IMU complementary attitude filter: directed and random samples.
`timescale 1ns / 1ps

module imu_complementary_attitude_filter_test;
    import imucf_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int SETTLE_CYCLES = 600;
    localparam int STALL_LIMIT = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    imucf_in_t s_data;
    logic m_valid;
    logic m_ready;
    imucf_out_t m_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    imu_complementary_attitude_filter #(.CORDIC_STEPS(CORDIC_STEPS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // filter state and registers as the predictor sees them
    logic [1:0] gyro_rng;
    logic [1:0] accel_rng;
    longint gyro_off[3];
    longint accel_off[3];
    logic [31:0] last_stamp;
    logic stamp_seen;
    longint angle_state[3];

    imucf_out_t angle_queue[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;
    logic [31:0] stim_time = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint atan_step(int i);
        case (i)
            0: return 2949120;   1: return 1740967;  2: return 919879;  3: return 466945;
            4: return 234379;    5: return 117304;   6: return 58666;   7: return 29335;
            8: return 14668;     9: return 7334;     10: return 3667;   11: return 1833;
            12: return 917;      13: return 458;     14: return 229;    15: return 115;
            16: return 57;       17: return 29;      18: return 14;     19: return 7;
            20: return 4;        21: return 2;       22: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint tilt_deg(longint a, longint b, longint c);
        longint unsigned sq;
        longint x, y, z, xs, ys;
        sq = longint'(b * b) + longint'(c * c);
        x = longint'(floor_sqrt(sq << 28));
        y = a * 16384;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += atan_step(i);
            end else begin
                x -= ys; y += xs; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint gyro_integrate(longint d, logic [31:0] dt, longint prev);
        longint unsigned dv, mag, prod, quo, rem, inc;
        case (gyro_rng)
            2'd0: dv = 131000;
            2'd1: dv = 65500;
            2'd2: dv = 32800;
            default: dv = 16400;
        endcase
        mag = (d < 0) ? -d : d;
        prod = mag * longint'(dt);
        quo = prod / dv;
        rem = prod % dv;
        inc = quo * 65536 + (rem * 65536 + dv / 2) / dv;
        return clamp32(prev + ((d < 0) ? -longint'(inc) : longint'(inc)));
    endfunction

    function automatic imucf_out_t predict_angles(imucf_in_t smp);
        longint acc[3], gy[3];
        logic [31:0] dt;
        imucf_out_t res;
        dt = stamp_seen ? smp.time_ms - last_stamp : 32'd0;
        acc[0] = longint'(smp.accel_raw_x);
        acc[1] = longint'(smp.accel_raw_y);
        acc[2] = longint'(smp.accel_raw_z);
        gy[0] = longint'(smp.gyro_raw_x);
        gy[1] = longint'(smp.gyro_raw_y);
        gy[2] = longint'(smp.gyro_raw_z);
        for (int i = 0; i < 3; i++) begin
            if (accel_rng != 2'd0) acc[i] -= accel_off[i];
            gy[i] = gyro_integrate(gy[i] - gyro_off[i], dt, angle_state[i]);
        end
        angle_state[0] = clamp32(round_div(24 * gy[0] + tilt_deg(acc[0], acc[1], acc[2]), 25));
        angle_state[1] = clamp32(round_div(24 * gy[1] + tilt_deg(acc[1], acc[0], acc[2]), 25));
        angle_state[2] = gy[2];
        last_stamp = smp.time_ms;
        stamp_seen = 1'b1;
        res.angle_x = angle_state[0][31:0];
        res.angle_y = angle_state[1][31:0];
        res.angle_z = angle_state[2][31:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field,
                 $signed(got), $signed(want), $realtime);
        error_count++;
    endtask

    // result checker and receiver backpressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (angle_queue.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                error_count++;
            end else begin
                imucf_out_t want;
                want = angle_queue.pop_front();
                if (m_data.angle_x !== want.angle_x)
                    report_mismatch("angle_x", m_data.angle_x, want.angle_x);
                if (m_data.angle_y !== want.angle_y)
                    report_mismatch("angle_y", m_data.angle_y, want.angle_y);
                if (m_data.angle_z !== want.angle_z)
                    report_mismatch("angle_z", m_data.angle_z, want.angle_z);
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // leaves cfg_we high; program_filter lowers it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_GYRO_RANGE: gyro_rng = val[1:0];
            REG_ACCEL_RANGE: accel_rng = val[1:0];
            REG_GYRO_OFF_X, REG_GYRO_OFF_Y, REG_GYRO_OFF_Z:
                gyro_off[idx - REG_GYRO_OFF_X] = longint'($signed(val));
            default: accel_off[idx - REG_ACCEL_OFF_X] = longint'(val[14:0]);
        endcase
    endtask

    task automatic program_filter(logic [1:0] grng, logic [1:0] arng,
                                  logic [15:0] goff, logic [15:0] aoff, bit rnd);
        write_reg(REG_GYRO_RANGE, {14'($urandom_range(16'h3fff)), grng});
        write_reg(REG_ACCEL_RANGE, {14'($urandom_range(16'h3fff)), arng});
        for (int i = 0; i < 3; i++)
            write_reg(REG_GYRO_OFF_X + 3'(i), rnd ? 16'($urandom_range(16'hffff)) : goff);
        for (int i = 0; i < 3; i++)
            write_reg(REG_ACCEL_OFF_X + 3'(i), rnd ? 16'($urandom_range(16'hffff)) : aoff);
        cfg_we <= 1'b0;
    endtask

    // leaves s_valid high after acceptance; release_input lowers it
    task automatic send_sample(imucf_in_t smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= smp;
        do @(posedge aclk); while (!s_ready);
        angle_queue.push_back(predict_angles(smp));
    endtask

    task automatic release_input();
        s_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        release_input();
        while (angle_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_raw();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'h7fff;
            2: return 16'h8000;
            3, 4: return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    function automatic imucf_in_t rand_sample();
        imucf_in_t smp;
        smp = {rand_raw(), rand_raw(), rand_raw(), rand_raw(), rand_raw(), rand_raw(), 32'd0};
        case ($urandom_range(19))
            0: stim_time = $urandom;
            1: stim_time = stim_time + $urandom_range(100000);
            default: stim_time = stim_time + $urandom_range(40);
        endcase
        smp.time_ms = stim_time;
        return smp;
    endfunction

    function automatic imucf_in_t make_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                              logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                                              logic [31:0] ts);
        imucf_in_t smp;
        smp = {ax, ay, az, gx, gy, gz, ts};
        return smp;
    endfunction

    task automatic test_directed();
        // first sample sees zero elapsed time
        send_sample(make_sample(16'h7fff, 16'h8000, 16'h0001, 16'h7fff, 16'h8000, 16'h7fff,
                                32'hffff_ffff));
        // timestamp wraps
        send_sample(make_sample(16'h0000, 16'h0000, 16'h4000, 16'h1000, 16'hf000, 16'h0000,
                                32'd9));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                32'd20));
        send_sample(make_sample(16'h4000, 16'h0000, 16'h0000, 16'h0001, 16'hffff, 16'h0001,
                                32'd30));
        send_sample(make_sample(16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                32'd31));
        send_sample(make_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                32'd31));
        send_sample(make_sample(16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h7fff, 16'h8000,
                                32'd32));
        // huge elapsed time saturates the integrated gyro angle of every axis
        send_sample(make_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                32'h8000_0000));
        send_sample(make_sample(16'h0100, 16'h0100, 16'h0100, 16'h7fff, 16'h7fff, 16'h7fff,
                                32'hf000_0000));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                32'h6000_0000));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                32'hffff_fffe));
        wait_idle();
        // offsets at extremes: accel offset cancels the sample to a zero vector
        program_filter(2'd3, 2'd3, 16'h8000, 16'h7fff, 1'b0);
        send_sample(make_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000,
                                32'd100));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff,
                                32'd5000));
        wait_idle();
        program_filter(2'd1, 2'd0, 16'h7fff, 16'hffff, 1'b0);
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000,
                                32'd5100));
        send_sample(make_sample(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                32'd5101));
        wait_idle();
    endtask

    task automatic run_random_phase(int sidle, int ridle, int items_per_cfg);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int c = 0; c < 4; c++) begin
            case (c)
                0: program_filter(2'd0, 2'd0, 16'h0000, 16'h0000, 1'b0);
                1: program_filter(2'd3, 2'd3, 16'h0000, 16'h0000, 1'b1);
                default: program_filter(2'($urandom_range(3)), 2'($urandom_range(3)),
                                        16'h0000, 16'h0000, 1'b1);
            endcase
            for (int n = 0; n < items_per_cfg; n++) begin
                send_sample(rand_sample());
                // hold off until the filter has drained
                if (n == items_per_cfg / 2) begin
                    release_input();
                    while (angle_queue.size() != 0) @(posedge aclk);
                end
            end
            wait_idle();
        end
    endtask

    task automatic test_sender_idles();
        run_random_phase(20, 76, 140);
    endtask

    task automatic test_receiver_idles();
        run_random_phase(76, 20, 140);
    endtask

    task automatic test_full_rate();
        run_random_phase(0, 0, 140);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        gyro_rng = 2'd0;
        accel_rng = 2'd0;
        last_stamp = 32'd0;
        stamp_seen = 1'b0;
        for (int i = 0; i < 3; i++) begin
            gyro_off[i] = 0;
            accel_off[i] = 0;
            angle_state[i] = 0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_sender_idles();
        test_receiver_idles();
        test_full_rate();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### imu_complementary_attitude_filter.f
sv/imucf_pkg.sv
sv/imucf_ctrl.sv
sv/imucf_datapath.sv
sv/imu_complementary_attitude_filter.sv
test/imu_complementary_attitude_filter_test.sv
